@@ hw/rtl/alfs_pkg.sv @@
// ----------------------------------------------------------------------------
// alfs_pkg: shared types and constants of the LED frame serializer
// Symbol codes, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package alfs_pkg;

  // symbol codes on the line
  localparam logic [1:0] SYM_GAP  = 2'd0;
  localparam logic [1:0] SYM_ZERO = 2'd1;
  localparam logic [1:0] SYM_ONE  = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 3;
  localparam logic [2:0]  CFG_ZERO_HIGH    = 3'd0;
  localparam logic [2:0]  CFG_ZERO_LOW     = 3'd1;
  localparam logic [2:0]  CFG_ONE_HIGH     = 3'd2;
  localparam logic [2:0]  CFG_ONE_LOW      = 3'd3;
  localparam logic [2:0]  CFG_RESET_GAP    = 3'd4;
  localparam int          CFG_DATA_W       = 16;

  localparam int TIME_W = 10;
  localparam int GAP_W  = 16;

  localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 10'd20;
  localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 10'd43;
  localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 10'd43;
  localparam logic [TIME_W-1:0] ONE_LOW_RST   = 10'd20;
  localparam logic [GAP_W-1:0]  GAP_RST       = 16'd2500;

  // one pixel is green, red, blue; top bit goes out first
  localparam int                   PIXEL_W   = 24;
  localparam int                   BIT_CNT_W = 5;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = 5'(PIXEL_W - 1);

  typedef struct packed {
    logic clear_write;
    logic accept;
    logic gap_read;
    logic gap_emit;
    logic load_first;
    logic bit_emit;
  } alfs_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
    logic bit_last;
    logic led_last;
  } alfs_stat_t;

endpackage

@@ hw/rtl/alfs_ifs.sv @@
// ----------------------------------------------------------------------------
// alfs_ifs: handshake channels of the LED frame serializer
// Pixel update channel and line symbol channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface alfs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, led_index, red_level, green_level, blue_level,
                  input ready);
  modport sink   (input valid, led_index, red_level, green_level, blue_level,
                  output ready);
endinterface

interface alfs_symbol_if;
  logic        valid;
  logic        ready;
  logic [1:0]  symbol_kind;
  logic [9:0]  high_time;
  logic [15:0] low_time;
  logic        index_rejected;
  logic        last_symbol;

  modport source (output valid, symbol_kind, high_time, low_time, index_rejected,
                  last_symbol, input ready);
  modport sink   (input valid, symbol_kind, high_time, low_time, index_rejected,
                  last_symbol, output ready);
endinterface

@@ hw/rtl/addressable_led_frame_serializer.sv @@
// ----------------------------------------------------------------------------
// addressable_led_frame_serializer: pixel update to LED refresh frame
// Stores one colour per LED and emits a whole line frame per update.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in takes one update word: LED index and red, green, blue bytes.
//   A valid index writes the colour store; an index at or above NUM_LEDS
//   leaves it untouched and sets index_rejected on every symbol of the frame.
//   symbol_out then carries 1 + 24*NUM_LEDS symbol words: one reset gap,
//   then per LED green, red, blue bytes, MSB first, as zero/one bit symbols
//   with their high and low times. last_symbol marks the final bit.
//   Sequence: the accept, the gap word, a store load step, then one bit
//   word per cycle while symbol_out does not stall. The next update is
//   taken once the last bit word is in the output register.
//   A stall on symbol_out holds the output register and freezes the frame.
//   Reset loads the timing defaults, then a clearing pass zeroes every
//   entry of the colour store; pixel_in.ready stays low during it.
//   cfg_we/cfg_index/cfg_data write timing registers; write only while idle.
// ----------------------------------------------------------------------------
module addressable_led_frame_serializer import alfs_pkg::*; #(
  parameter int NUM_LEDS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  alfs_pixel_if.sink            pixel_in,
  alfs_symbol_if.source         symbol_out
);

  alfs_cmd_t  cmd;
  alfs_stat_t stat;

  // sequencer: clearing pass, accept, gap, bit stream
  alfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (pixel_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, shifter and the output register that parts the two channels
  alfs_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .led_index      (pixel_in.led_index),
    .red_level      (pixel_in.red_level),
    .green_level    (pixel_in.green_level),
    .blue_level     (pixel_in.blue_level),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (symbol_out.valid),
    .out_ready      (symbol_out.ready),
    .symbol_kind    (symbol_out.symbol_kind),
    .high_time      (symbol_out.high_time),
    .low_time       (symbol_out.low_time),
    .index_rejected (symbol_out.index_rejected),
    .last_symbol    (symbol_out.last_symbol)
  );

  // one update at a time: ready drops right after an accept
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    pixel_in.valid && pixel_in.ready |=> !pixel_in.ready)
    else $error("update accepted while a frame is in progress");

  // after the final bit word leaves, only a new frame's gap may follow
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    symbol_out.valid && symbol_out.ready && symbol_out.last_symbol |=>
    !symbol_out.valid || symbol_out.symbol_kind == SYM_GAP)
    else $error("bit word emitted after end of frame");

  // a gap word has no high part and never ends a frame
  a_gap_shape: assert property (@(posedge clk) disable iff (rst)
    symbol_out.valid && symbol_out.symbol_kind == SYM_GAP |->
    symbol_out.high_time == '0 && !symbol_out.last_symbol)
    else $error("malformed reset gap word");

  // a new frame only starts while the output is free of the previous one
  a_gap_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_in.valid && pixel_in.ready |=> !symbol_out.valid ||
    symbol_out.last_symbol || symbol_out.symbol_kind == SYM_GAP)
    else $error("frame overlaps previous frame");

endmodule

@@ hw/rtl/alfs_ram.sv @@
// ----------------------------------------------------------------------------
// alfs_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/alfs_datapath.sv @@
// ----------------------------------------------------------------------------
// alfs_datapath: colour store, bit shifter and symbol output register
// Executes controller commands and reports counter status back.
// ----------------------------------------------------------------------------
module alfs_datapath import alfs_pkg::*; #(
  parameter int NUM_LEDS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            led_index,
  input  logic [7:0]            red_level,
  input  logic [7:0]            green_level,
  input  logic [7:0]            blue_level,
  input  alfs_cmd_t             cmd,
  output alfs_stat_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            symbol_kind,
  output logic [TIME_W-1:0]     high_time,
  output logic [GAP_W-1:0]      low_time,
  output logic                  index_rejected,
  output logic                  last_symbol
);

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  logic [TIME_W-1:0]    zero_high;
  logic [TIME_W-1:0]    zero_low;
  logic [TIME_W-1:0]    one_high;
  logic [TIME_W-1:0]    one_low;
  logic [GAP_W-1:0]     gap_len;

  logic [AW-1:0]        clr_cnt;
  logic [AW-1:0]        led_cnt;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [PIXEL_W-1:0]   shifter;
  logic                 rejected;

  logic                 in_range;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [PIXEL_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [PIXEL_W-1:0]   ram_rdata;
  logic [31:0]          ahead_idx;
  logic                 next_led;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high <= ZERO_HIGH_RST;
      zero_low  <= ZERO_LOW_RST;
      one_high  <= ONE_HIGH_RST;
      one_low   <= ONE_LOW_RST;
      gap_len   <= GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZERO_HIGH: zero_high <= cfg_data[TIME_W-1:0];
        CFG_ZERO_LOW:  zero_low  <= cfg_data[TIME_W-1:0];
        CFG_ONE_HIGH:  one_high  <= cfg_data[TIME_W-1:0];
        CFG_ONE_LOW:   one_low   <= cfg_data[TIME_W-1:0];
        CFG_RESET_GAP: gap_len   <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_range  = 32'(led_index) < NUM_LEDS;
  assign stat.bit_last   = bit_cnt == LAST_BIT;
  assign stat.led_last   = led_cnt == AW'(NUM_LEDS - 1);
  assign stat.clear_done = clr_cnt == AW'(NUM_LEDS - 1);
  assign stat.out_free   = !out_valid || out_ready;

  // move on to the next LED after its last bit
  assign next_led = cmd.bit_emit && stat.bit_last && !stat.led_last;

  // store writes: clearing pass or pixel update
  assign ram_we    = cmd.clear_write || (cmd.accept && in_range);
  assign ram_waddr = cmd.clear_write ? clr_cnt : AW'(led_index);
  assign ram_wdata = cmd.clear_write ? '0 : {green_level, red_level, blue_level};

  // prefetch the LED after the one being loaded
  assign ahead_idx = 32'(led_cnt) + (cmd.load_first ? 32'd1 : 32'd2);
  assign ram_re    = cmd.gap_read ||
                     ((cmd.load_first || next_led) && (ahead_idx < NUM_LEDS));
  assign ram_raddr = cmd.gap_read ? '0 : AW'(ahead_idx);

  alfs_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (NUM_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      led_cnt <= '0;
      bit_cnt <= '0;
    end else begin
      if (cmd.clear_write) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.accept) begin
        led_cnt <= '0;
      end else if (next_led) begin
        led_cnt <= led_cnt + AW'(1);
      end
      if (cmd.load_first) begin
        bit_cnt <= '0;
      end else if (cmd.bit_emit) begin
        bit_cnt <= stat.bit_last ? '0 : bit_cnt + BIT_CNT_W'(1);
      end
    end
  end

  // shifter and reject flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rejected <= !in_range;
    end
    if (cmd.load_first || next_led) begin
      shifter <= ram_rdata;
    end else if (cmd.bit_emit) begin
      shifter <= {shifter[PIXEL_W-2:0], 1'b0};
    end
  end

  // symbol output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.gap_emit || cmd.bit_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gap_emit) begin
      symbol_kind    <= SYM_GAP;
      high_time      <= '0;
      low_time       <= gap_len;
      index_rejected <= rejected;
      last_symbol    <= 1'b0;
    end else if (cmd.bit_emit) begin
      symbol_kind    <= shifter[PIXEL_W-1] ? SYM_ONE : SYM_ZERO;
      high_time      <= shifter[PIXEL_W-1] ? one_high : zero_high;
      low_time       <= GAP_W'(shifter[PIXEL_W-1] ? one_low : zero_low);
      index_rejected <= rejected;
      last_symbol    <= stat.bit_last && stat.led_last;
    end
  end

endmodule

@@ hw/rtl/alfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// alfs_ctrl: frame sequencer
// Runs the clearing pass, takes an update and steps through the frame.
// ----------------------------------------------------------------------------
module alfs_ctrl import alfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  alfs_stat_t stat,
  output alfs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_GAP,
    S_LOAD,
    S_BITS
  } state_t;

  state_t state;

  always_comb begin
    cmd.clear_write = state == S_CLEAR;
    cmd.accept      = in_ready && in_valid;
    cmd.gap_read    = state == S_GAP;
    cmd.gap_emit    = (state == S_GAP) && stat.out_free;
    cmd.load_first  = state == S_LOAD;
    cmd.bit_emit    = (state == S_BITS) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (stat.clear_done) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.accept) begin
            state    <= S_GAP;
            in_ready <= 1'b0;
          end
        end
        S_GAP: begin
          if (cmd.gap_emit) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_BITS;
        end
        S_BITS: begin
          if (cmd.bit_emit && stat.bit_last && stat.led_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ dv/addressable_led_frame_serializer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_frame_serializer_tb: self-checking bench of the serializer
// Sends pixel update words and predicts each refresh frame symbol by symbol
// from a local colour store and timing shadow. Every symbol word is checked
// field by field. The run covers directed corner cases, then random traffic
// with random stalls on both channels and several timing settings.
// ----------------------------------------------------------------------------
module addressable_led_frame_serializer_tb;
  import alfs_pkg::*;

  localparam int NUM_LEDS       = 2;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_PIXELS  = 180;
  localparam int PHASE_LEN      = 45;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;
  // Worst case is roughly every update times its 49 words at the longest
  // stall, plus frame and gap time; allow several times that.
  localparam int CYCLE_LIMIT    = 3_000_000;

  // One line symbol as it leaves the block.
  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] high;
    logic [GAP_W-1:0]  low;
    logic              rejected;
    logic              last;
  } line_symbol_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alfs_pixel_if  pix ();
  alfs_symbol_if sym ();

  addressable_led_frame_serializer #(
    .NUM_LEDS (NUM_LEDS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pix),
    .symbol_out (sym)
  );

  // Shadow of the timing registers, updated at the edge that writes them.
  logic [TIME_W-1:0] zero_high_t;
  logic [TIME_W-1:0] zero_low_t;
  logic [TIME_W-1:0] one_high_t;
  logic [TIME_W-1:0] one_low_t;
  logic [GAP_W-1:0]  gap_t;

  // Local colour store, same depth as the chain.
  logic [7:0] red_mem   [NUM_LEDS];
  logic [7:0] green_mem [NUM_LEDS];
  logic [7:0] blue_mem  [NUM_LEDS];

  // Symbols predicted but not yet seen on the output, oldest first.
  line_symbol_t pending_symbols[$];

  int error_count;
  int cycle_count;
  int words_seen;
  int ready_hold;
  bit sink_stalls;   // let the symbol side drop ready at random
  bit source_gaps;   // let the pixel side idle between words

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run; a correct one finishes far below this.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("addressable_led_frame_serializer_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Random pacing: half the time no gap, often a short one, now and then a long one.
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Favor the byte extremes, otherwise any value.
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Register value: zero, one, all ones of the register, all ones of the
  // port (upper bits must be dropped), or anything on the port.
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return CFG_DATA_W'(1);
    if (roll == 2) return CFG_DATA_W'((1 << width) - 1);
    if (roll == 3) return '1;
    return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] mismatch on %s at symbol word %0d: got 0x%0h, want 0x%0h",
               $time, what, words_seen, seen, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Frame prediction
  // --------------------------------------------------------------------------
  function automatic line_symbol_t bit_symbol(input bit one, input bit rejected,
                                              input bit last);
    line_symbol_t s;
    s.kind     = one ? SYM_ONE : SYM_ZERO;
    s.high     = one ? one_high_t : zero_high_t;
    s.low      = GAP_W'(one ? one_low_t : zero_low_t);
    s.rejected = rejected;
    s.last     = last;
    return s;
  endfunction

  // Apply one update to the store and queue the whole frame it causes:
  // reset gap, then green, red, blue of every LED, top bit first.
  function automatic void predict_frame(input logic [7:0] index, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue);
    line_symbol_t       gap_sym;
    logic [PIXEL_W-1:0] grb;
    bit                 rejected;
    int                 led;
    int                 b;
    rejected = (index >= NUM_LEDS);
    if (!rejected) begin
      red_mem[index]   = red;
      green_mem[index] = green;
      blue_mem[index]  = blue;
    end
    gap_sym.kind     = SYM_GAP;
    gap_sym.high     = '0;
    gap_sym.low      = gap_t;
    gap_sym.rejected = rejected;
    gap_sym.last     = 1'b0;
    pending_symbols.push_back(gap_sym);
    for (led = 0; led < NUM_LEDS; led++) begin
      grb = {green_mem[led], red_mem[led], blue_mem[led]};
      for (b = PIXEL_W - 1; b >= 0; b--)
        pending_symbols.push_back(bit_symbol(grb[b], rejected,
                                             (led == NUM_LEDS - 1) && (b == 0)));
    end
  endfunction

  // Predict on every accepted pixel word.
  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready)
      predict_frame(pix.led_index, pix.red_level, pix.green_level, pix.blue_level);
  end

  // Compare every accepted symbol word with the oldest prediction.
  always @(posedge clk) begin : symbol_check
    line_symbol_t seen;
    line_symbol_t want;
    if (!rst && sym.valid && sym.ready) begin
      seen = '{sym.symbol_kind, sym.high_time, sym.low_time, sym.index_rejected,
               sym.last_symbol};
      if (pending_symbols.size() == 0) begin
        report_mismatch("symbol word with no frame pending", seen, 0);
      end else begin
        want = pending_symbols.pop_front();
        if (seen.kind !== want.kind)
          report_mismatch("symbol_kind", seen.kind, want.kind);
        if (seen.high !== want.high)
          report_mismatch("high_time", seen.high, want.high);
        if (seen.low !== want.low)
          report_mismatch("low_time", seen.low, want.low);
        if (seen.rejected !== want.rejected)
          report_mismatch("index_rejected", seen.rejected, want.rejected);
        if (seen.last !== want.last)
          report_mismatch("last_symbol", seen.last, want.last);
      end
      words_seen++;
    end
  end

  // Symbol side pacing: hold ready for a random run, then drop it for a
  // random gap. Keep it high whenever stalls are off.
  always @(posedge clk) begin : sink_pacing
    int stall;
    if (rst) begin
      sym.ready  <= 1'b0;
      ready_hold <= 0;
    end else if (!sink_stalls) begin
      sym.ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      stall = idle_len();
      sym.ready  <= (stall == 0);
      ready_hold <= (stall == 0) ? $urandom_range(0, 6) : stall - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one pixel word and return at the edge that takes it. Valid stays
  // high on return so back-to-back words need no drop in between.
  task automatic send_pixel(input logic [7:0] index, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    int gap;
    gap = source_gaps ? idle_len() : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.led_index   <= index;
    pix.red_level   <= red;
    pix.green_level <= green;
    pix.blue_level  <= blue;
    do @(posedge clk); while (!pix.ready);
  endtask

  // Drop valid and hold until every predicted symbol has come out; then
  // wait the given number of extra cycles.
  task automatic drain_frames(input int settle);
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write one timing register; only call while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_ZERO_HIGH: zero_high_t = value[TIME_W-1:0];
      CFG_ZERO_LOW:  zero_low_t  = value[TIME_W-1:0];
      CFG_ONE_HIGH:  one_high_t  = value[TIME_W-1:0];
      CFG_ONE_LOW:   one_low_t   = value[TIME_W-1:0];
      CFG_RESET_GAP: gap_t       = value[GAP_W-1:0];
      default: ;  // indexes past the list change nothing
    endcase
  endtask

  task automatic write_all_timing(input logic [CFG_DATA_W-1:0] zero_high,
                                  input logic [CFG_DATA_W-1:0] zero_low,
                                  input logic [CFG_DATA_W-1:0] one_high,
                                  input logic [CFG_DATA_W-1:0] one_low,
                                  input logic [CFG_DATA_W-1:0] gap);
    write_reg(CFG_ZERO_HIGH, zero_high);
    write_reg(CFG_ZERO_LOW,  zero_low);
    write_reg(CFG_ONE_HIGH,  one_high);
    write_reg(CFG_ONE_LOW,   one_low);
    write_reg(CFG_RESET_GAP, gap);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Frames straight after reset: default timing, all-zero store. Run the
  // first one rejected so the cleared store is seen untouched.
  task automatic test_reset_frame();
    sink_stalls = 1'b0;
    source_gaps = 1'b0;
    send_pixel(8'd2, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0, 8'h00, 8'hFF, 8'h01);
    drain_frames(0);
  endtask

  // Index and colour extremes, with stalls on both sides. Out-of-range
  // updates must leave the store as it was and flag every symbol.
  task automatic test_pixel_extremes();
    sink_stalls = 1'b1;
    source_gaps = 1'b1;
    send_pixel(8'd1,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0,   8'h80, 8'h01, 8'hAA);
    send_pixel(8'd255, 8'h12, 8'h34, 8'h56);
    send_pixel(8'd1,   8'h55, 8'hAA, 8'h00);
    send_pixel(8'd128, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd127, 8'hC3, 8'h3C, 8'h7E);
    send_pixel(8'd1,   8'h00, 8'h00, 8'h00);
    send_pixel(8'd0,   8'hFF, 8'h00, 8'hFF);
    drain_frames(0);
  endtask

  // Timing register corners: zero lengths pass as given, full-scale values,
  // port values wider than the register keep only the low bits, and writes
  // past the register list are ignored.
  task automatic test_timing_registers();
    logic [CFG_IDX_W-1:0] idx;
    sink_stalls = 1'b1;
    source_gaps = 1'b1;

    write_all_timing('0, '0, '0, '0, '0);
    send_pixel(8'd0, 8'hA5, 8'h5A, 8'hF0);
    drain_frames(0);

    write_all_timing(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'hFFFF);
    send_pixel(8'd1, 8'h0F, 8'hF0, 8'h81);
    drain_frames(0);

    write_all_timing(16'hFFFF, 16'hFC01, 16'hFC00, 16'h8001, 16'd1);
    send_pixel(8'd0, 8'hFF, 8'h00, 8'h80);
    drain_frames(0);

    // Junk to the unused indexes must not disturb the settings above.
    for (idx = CFG_RESET_GAP + 3'd1; idx != '0; idx++)
      write_reg(idx, 16'h5A5A);
    send_pixel(8'd200, 8'h11, 8'h22, 8'h33);
    drain_frames(0);

    write_all_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_pixel(8'd1, 8'h80, 8'h01, 8'h7F);
    drain_frames(0);

    write_all_timing(ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST, GAP_RST);
  endtask

  // Random updates, mostly to LEDs in the chain, in phases with fresh
  // timing and pacing. Once mid-run (and now and then at random) hold the
  // sender until every frame has left.
  task automatic test_random_traffic();
    int         i;
    logic [7:0] index;
    for (i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % PHASE_LEN == 0) begin
        drain_frames(0);
        write_all_timing(pick_reg_value(TIME_W), pick_reg_value(TIME_W),
                         pick_reg_value(TIME_W), pick_reg_value(TIME_W),
                         pick_reg_value(GAP_W));
        if ($urandom_range(0, 1))
          write_reg(CFG_IDX_W'($urandom_range(CFG_RESET_GAP + 1, 7)),
                    CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        // Keep the first phase free of stalls on both sides.
        sink_stalls = (i != 0) && ($urandom_range(0, 3) != 0);
        source_gaps = (i != 0) && ($urandom_range(0, 3) != 0);
      end else if (i == RANDOM_PIXELS / 2 || $urandom_range(0, 29) == 0) begin
        drain_frames(0);
      end
      if ($urandom_range(0, 99) < 85)
        index = 8'($urandom_range(0, NUM_LEDS - 1));
      else
        index = 8'($urandom_range(NUM_LEDS, 255));
      send_pixel(index, pick_level(), pick_level(), pick_level());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    pix.valid       = 1'b0;
    pix.led_index   = '0;
    pix.red_level   = '0;
    pix.green_level = '0;
    pix.blue_level  = '0;
    sym.ready       = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    words_seen      = 0;
    sink_stalls     = 1'b0;
    source_gaps     = 1'b0;

    // Timing defaults and an empty colour store, as after reset.
    zero_high_t = ZERO_HIGH_RST;
    zero_low_t  = ZERO_LOW_RST;
    one_high_t  = ONE_HIGH_RST;
    one_low_t   = ONE_LOW_RST;
    gap_t       = GAP_RST;
    for (int led = 0; led < NUM_LEDS; led++) begin
      red_mem[led]   = '0;
      green_mem[led] = '0;
      blue_mem[led]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold off until the store clearing pass is over.
    while (!pix.ready) @(posedge clk);

    test_reset_frame();
    test_pixel_extremes();
    test_timing_registers();
    test_random_traffic();

    // Let the last frames out, then watch a little longer for stray words.
    drain_frames(SETTLE_CYCLES);

    if (error_count == 0) begin
      $display("addressable_led_frame_serializer_tb: clean");
    end else begin
      $display("addressable_led_frame_serializer_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/alfs_pkg.sv
hw/rtl/alfs_ifs.sv
hw/rtl/alfs_ram.sv
hw/rtl/alfs_datapath.sv
hw/rtl/alfs_ctrl.sv
hw/rtl/addressable_led_frame_serializer.sv
dv/addressable_led_frame_serializer_tb.sv
